// File: hdl/value_stack_with_search_remove_macros.svh
// assertion macros used by the checker file
`ifndef VALUE_STACK_WITH_SEARCH_REMOVE_MACROS_SVH
`define VALUE_STACK_WITH_SEARCH_REMOVE_MACROS_SVH

// same-cycle implication, reset masks the check
`define VSTK_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define VSTK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/vstk_pkg.sv
package vstk_pkg;

  // storage geometry
  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 16;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // request fields
  localparam int OP_W        = 3;
  localparam int VAL_W       = 16;
  localparam int IN_OP_LSB   = 0;
  localparam int IN_VAL_LSB  = IN_OP_LSB + OP_W;
  localparam int IN_TDATA_W  = 24;

  // result fields
  localparam int RD_W        = 16;
  localparam int RCNT_W      = 7;
  localparam int OUT_RD_LSB    = 0;
  localparam int OUT_EMPTY_BIT = OUT_RD_LSB + RD_W;
  localparam int OUT_HIT_BIT   = OUT_EMPTY_BIT + 1;
  localparam int OUT_REM_LSB   = OUT_HIT_BIT + 1;
  localparam int OUT_FILL_LSB  = OUT_REM_LSB + RCNT_W;
  localparam int OUT_OVF_BIT   = OUT_FILL_LSB + RCNT_W;
  localparam int OUT_USED_W    = OUT_OVF_BIT + 1;
  localparam int OUT_TDATA_W   = 40;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH       = 3'd0;
  localparam logic [OP_W-1:0] OP_POP        = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK       = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE     = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE_ALL = 3'd4;
  localparam logic [OP_W-1:0] OP_CONTAINS   = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

endpackage

// File: hdl/value_stack_with_search_remove.sv
// Bounded LIFO of 64 values (16 bits) with search and delete by value, one result per
// request. Entries live in a single-port-read, single-port-write synchronous RAM, so
// every pass over the stack moves one entry per cycle. Push, clear and the unused code
// go straight to the result state; pop and peek first read the top entry. Contains and
// remove scan from the top down, one RAM read a cycle, until a match or the bottom.
// Remove first match scans down to the match at index i and then shifts the entries
// above it down one place. Remove all compacts the whole stack in one upward pass. The
// result sits in an output register, so a new request is accepted while the previous
// result waits; the next result then waits as long as out_tready holds the register.
// in_tdata: op [2:0], value [18:3]. out_tdata: read_value [15:0], was_empty [16],
// hit [17], removed_count [24:18], fill_level [31:25], overflow [32].
module value_stack_with_search_remove (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // op, value
  input  logic [vstk_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // read_value, was_empty, hit, removed_count, fill_level, overflow
  output logic [vstk_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int CW = vstk_pkg::CNT_W;
  localparam int AW = vstk_pkg::ADDR_W;
  localparam int DW = vstk_pkg::DATA_WIDTH;

  // state codes
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_READ    = 3'd1;
  localparam logic [2:0] S_SEARCH  = 3'd2;
  localparam logic [2:0] S_COMPACT = 3'd3;
  localparam logic [2:0] S_FIN     = 3'd4;

  logic [2:0]                    state_r, state_nxt;
  logic [vstk_pkg::OP_W-1:0]     op_r, op_nxt;
  logic [DW-1:0]                 val_r, val_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [CW-1:0]                 rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]                 wr_ptr_r, wr_ptr_nxt;
  logic                          pend_r, pend_nxt;

  logic [DW-1:0]                 res_rd_r, res_rd_nxt;
  logic                          res_empty_r, res_empty_nxt;
  logic                          res_hit_r, res_hit_nxt;
  logic [CW-1:0]                 res_rem_r, res_rem_nxt;
  logic                          res_ovf_r, res_ovf_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [vstk_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [DW-1:0]                 mem_q [vstk_pkg::DEPTH];
  logic [DW-1:0]                 mem_rdata_r;
  logic                          mem_we, mem_re;
  logic [AW-1:0]                 mem_waddr, mem_raddr;
  logic [DW-1:0]                 mem_wdata;

  logic                          accept;
  logic                          out_free;
  logic [vstk_pkg::OP_W-1:0]     in_op;
  logic [DW-1:0]                 in_val;
  logic [CW-1:0]                 cnt_dec;
  logic [CW-1:0]                 rd_dec;
  logic                          data_match;

  // request fields and handshake
  assign in_op     = in_tdata[vstk_pkg::IN_OP_LSB +: vstk_pkg::OP_W];
  assign in_val    = in_tdata[vstk_pkg::IN_VAL_LSB +: DW];
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign cnt_dec    = cnt_r - CW'(1);
  assign rd_dec     = rd_ptr_r - CW'(1);
  assign data_match = (mem_rdata_r == val_r);

  // entry memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem_q[mem_raddr];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    pend_nxt      = 1'b0;
    res_rd_nxt    = res_rd_r;
    res_empty_nxt = res_empty_r;
    res_hit_nxt   = res_hit_r;
    res_rem_nxt   = res_rem_r;
    res_ovf_nxt   = res_ovf_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r[AW-1:0];
    mem_wdata     = in_val;
    mem_re        = 1'b0;
    mem_raddr     = cnt_dec[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt        = in_op;
          val_nxt       = in_val;
          res_rd_nxt    = '0;
          res_empty_nxt = 1'b0;
          res_hit_nxt   = 1'b0;
          res_rem_nxt   = '0;
          res_ovf_nxt   = 1'b0;
          state_nxt     = S_FIN;
          unique case (in_op) inside
            vstk_pkg::OP_PUSH: begin
              if (cnt_r == CW'(vstk_pkg::DEPTH)) begin
                res_ovf_nxt = 1'b1;
              end else begin
                mem_we  = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            vstk_pkg::OP_POP, vstk_pkg::OP_PEEK: begin
              if (cnt_r == '0) begin
                res_empty_nxt = 1'b1;
              end else begin
                mem_re    = 1'b1;
                state_nxt = S_READ;
              end
            end
            vstk_pkg::OP_REMOVE, vstk_pkg::OP_CONTAINS: begin
              // downward scan starts just above the top
              rd_ptr_nxt = cnt_r;
              state_nxt  = S_SEARCH;
            end
            vstk_pkg::OP_REMOVE_ALL: begin
              rd_ptr_nxt = '0;
              wr_ptr_nxt = '0;
              state_nxt  = S_COMPACT;
            end
            vstk_pkg::OP_CLEAR: begin
              res_rem_nxt = cnt_r;
              res_hit_nxt = (cnt_r != '0);
              cnt_nxt     = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_READ: begin
        // top entry arrives from the memory
        res_rd_nxt = mem_rdata_r;
        if (op_r == vstk_pkg::OP_POP) begin
          cnt_nxt     = cnt_dec;
          res_rem_nxt = CW'(1);
        end
        state_nxt = S_FIN;
      end

      S_SEARCH: begin
        // pending read came from address rd_ptr_r
        if (pend_r && data_match) begin
          res_hit_nxt = 1'b1;
          if (op_r == vstk_pkg::OP_REMOVE) begin
            rd_ptr_nxt = rd_ptr_r + CW'(1);
            wr_ptr_nxt = rd_ptr_r;
            state_nxt  = S_COMPACT;
          end else begin
            state_nxt = S_FIN;
          end
        end else if (!pend_r && rd_ptr_r == '0) begin
          state_nxt = S_FIN;
        end else if (rd_ptr_r != '0) begin
          mem_re     = 1'b1;
          mem_raddr  = rd_dec[AW-1:0];
          rd_ptr_nxt = rd_dec;
          pend_nxt   = 1'b1;
        end
      end

      S_COMPACT: begin
        // write back kept entries, drop matches in remove-all mode
        if (pend_r) begin
          if (!(op_r == vstk_pkg::OP_REMOVE_ALL && data_match)) begin
            mem_we     = 1'b1;
            mem_waddr  = wr_ptr_r[AW-1:0];
            mem_wdata  = mem_rdata_r;
            wr_ptr_nxt = wr_ptr_r + CW'(1);
          end
        end
        if (rd_ptr_r < cnt_r) begin
          mem_re     = 1'b1;
          mem_raddr  = rd_ptr_r[AW-1:0];
          rd_ptr_nxt = rd_ptr_r + CW'(1);
          pend_nxt   = 1'b1;
        end else if (!pend_r) begin
          cnt_nxt     = wr_ptr_r;
          res_rem_nxt = cnt_r - wr_ptr_r;
          res_hit_nxt = (cnt_r != wr_ptr_r);
          state_nxt   = S_FIN;
        end
      end

      S_FIN: begin
        // hand the result to the output register
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {
            (vstk_pkg::OUT_TDATA_W - vstk_pkg::OUT_USED_W)'(0),
            res_ovf_r,
            vstk_pkg::RCNT_W'(cnt_r),
            vstk_pkg::RCNT_W'(res_rem_r),
            res_hit_r,
            res_empty_r,
            vstk_pkg::RD_W'(res_rd_r)
          };
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    val_r       <= val_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    wr_ptr_r    <= wr_ptr_nxt;
    res_rd_r    <= res_rd_nxt;
    res_empty_r <= res_empty_nxt;
    res_hit_r   <= res_hit_nxt;
    res_rem_r   <= res_rem_nxt;
    res_ovf_r   <= res_ovf_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: hdl/vstk_checker.sv
`include "value_stack_with_search_remove_macros.svh"

module vstk_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [vstk_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic [vstk_pkg::RCNT_W-1:0] fill;
  logic [vstk_pkg::RD_W-1:0]   rd_val;
  logic                        empty;
  logic                        ovf;

  assign fill   = out_tdata[vstk_pkg::OUT_FILL_LSB +: vstk_pkg::RCNT_W];
  assign rd_val = out_tdata[vstk_pkg::OUT_RD_LSB +: vstk_pkg::RD_W];
  assign empty  = out_tdata[vstk_pkg::OUT_EMPTY_BIT];
  assign ovf    = out_tdata[vstk_pkg::OUT_OVF_BIT];

  // a stalled result holds
  `VSTK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  // fill level never exceeds the depth
  `VSTK_ASSERT_NOW(a_fill_max, clk, rst_n, out_tvalid, fill <= vstk_pkg::RCNT_W'(vstk_pkg::DEPTH), "fill level above depth")
  // refused push only happens on a full stack
  `VSTK_ASSERT_NOW(a_ovf_full, clk, rst_n, out_tvalid && ovf, fill == vstk_pkg::RCNT_W'(vstk_pkg::DEPTH) && !empty, "overflow without full stack")
  // an empty read returns zero on an empty stack
  `VSTK_ASSERT_NOW(a_empty_read, clk, rst_n, out_tvalid && empty, fill == '0 && rd_val == '0, "empty read with stored entries")

endmodule

bind value_stack_with_search_remove vstk_checker u_vstk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
